// ===== rtl/core/pll_pkg.sv =====
// Shared types, constants and codes of the pooled linked list engine.
package pll_pkg;

	localparam int POOL_SLOTS_DEF = 16;
	localparam int VALUE_W        = 32;
	localparam int STATUS_W       = 2;
	localparam int SLOT_W         = 4;

	localparam logic MODE_INSERT = 1'b0;
	localparam logic MODE_REMOVE = 1'b1;

	localparam logic [STATUS_W-1:0] RES_DONE = 2'd0;
	localparam logic [STATUS_W-1:0] RES_FULL = 2'd1;
	localparam logic [STATUS_W-1:0] RES_MISS = 2'd2;

	typedef struct packed {
		logic                      mode;
		logic signed [VALUE_W-1:0] value;
	} pll_in_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [SLOT_W-1:0]   slot;
	} pll_out_t;

	typedef enum logic [3:0] {
		ST_INIT,
		ST_IDLE,
		ST_START,
		ST_FREE_UPD,
		ST_WALK_CHK,
		ST_WALK_EVAL,
		ST_INS_LINK,
		ST_INS_PREV,
		ST_REM_UNLINK,
		ST_REM_PUSH,
		ST_DONE_OK,
		ST_DONE_FULL,
		ST_DONE_MISS
	} pll_state_t;

	typedef struct packed {
		logic                load;
		logic                init_wr;
		logic                free_rd;
		logic                free_upd;
		logic                walk_init;
		logic                prev_tail;
		logic                walk_rd;
		logic                walk_adv;
		logic                ins_link;
		logic                ins_prev;
		logic                rem_unlink;
		logic                rem_push;
		logic                emit;
		logic [STATUS_W-1:0] res;
	} pll_cmd_t;

	typedef struct packed {
		logic init_last;
		logic mode;
		logic sorted;
		logic pool_full;
		logic walk_more;
		logic ge;
		logic eq;
		logic gt;
		logic link_prev;
		logic out_free;
	} pll_sts_t;

endpackage

// ===== rtl/core/pll_ctrl.sv =====
// Controller state machine: sequences init sweep, list walks and link updates.
module pll_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  pll_pkg::pll_sts_t sts,
	output pll_pkg::pll_cmd_t cmd
);
	import pll_pkg::*;

	pll_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_INIT: begin
				if (sts.init_last) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (in_valid) state_d = ST_START;
			end
			ST_START: begin
				if (sts.mode == MODE_INSERT) begin
					state_d = sts.pool_full ? ST_DONE_FULL : ST_FREE_UPD;
				end else begin
					state_d = ST_WALK_CHK;
				end
			end
			ST_FREE_UPD: begin
				state_d = sts.sorted ? ST_WALK_CHK : ST_INS_LINK;
			end
			ST_WALK_CHK: begin
				if (sts.walk_more) begin
					state_d = ST_WALK_EVAL;
				end else begin
					state_d = (sts.mode == MODE_INSERT) ? ST_INS_LINK : ST_DONE_MISS;
				end
			end
			ST_WALK_EVAL: begin
				if (sts.mode == MODE_INSERT) begin
					state_d = sts.ge ? ST_INS_LINK : ST_WALK_CHK;
				end else if (sts.eq) begin
					state_d = ST_REM_UNLINK;
				end else if (sts.sorted && sts.gt) begin
					state_d = ST_DONE_MISS;
				end else begin
					state_d = ST_WALK_CHK;
				end
			end
			ST_INS_LINK: begin
				state_d = sts.link_prev ? ST_INS_PREV : ST_DONE_OK;
			end
			ST_INS_PREV:   state_d = ST_DONE_OK;
			ST_REM_UNLINK: state_d = ST_REM_PUSH;
			ST_REM_PUSH:   state_d = ST_DONE_OK;
			ST_DONE_OK, ST_DONE_FULL, ST_DONE_MISS: begin
				if (sts.out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		cmd.res  = RES_DONE;
		in_ready = 1'b0;
		case (state_q)
			ST_INIT: cmd.init_wr = 1'b1;
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			ST_START: begin
				if (sts.mode == MODE_INSERT) begin
					cmd.free_rd = !sts.pool_full;
				end else begin
					cmd.walk_init = 1'b1;
				end
			end
			ST_FREE_UPD: begin
				cmd.free_upd  = 1'b1;
				cmd.walk_init = sts.sorted;
				cmd.prev_tail = !sts.sorted;
			end
			ST_WALK_CHK: cmd.walk_rd = sts.walk_more;
			ST_WALK_EVAL: begin
				if (sts.mode == MODE_INSERT) begin
					cmd.walk_adv = !sts.ge;
				end else begin
					cmd.walk_adv = !sts.eq && !(sts.sorted && sts.gt);
				end
			end
			ST_INS_LINK:   cmd.ins_link   = 1'b1;
			ST_INS_PREV:   cmd.ins_prev   = 1'b1;
			ST_REM_UNLINK: cmd.rem_unlink = 1'b1;
			ST_REM_PUSH:   cmd.rem_push   = 1'b1;
			ST_DONE_OK: begin
				cmd.emit = sts.out_free;
				cmd.res  = RES_DONE;
			end
			ST_DONE_FULL: begin
				cmd.emit = sts.out_free;
				cmd.res  = RES_FULL;
			end
			ST_DONE_MISS: begin
				cmd.emit = sts.out_free;
				cmd.res  = RES_MISS;
			end
			default: cmd = '0;
		endcase
	end

endmodule

// ===== rtl/core/pll_datapath.sv =====
// Datapath: node pools, list pointers, walk registers and result register.
module pll_datapath #(
	parameter int POOL_SLOTS = pll_pkg::POOL_SLOTS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_valid,
	input  logic              cfg_data,
	input  pll_pkg::pll_in_t  in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output pll_pkg::pll_out_t out_data,
	input  pll_pkg::pll_cmd_t cmd,
	output pll_pkg::pll_sts_t sts
);
	import pll_pkg::*;

	localparam int PW = $clog2(POOL_SLOTS + 1);
	localparam int IW = $clog2(POOL_SLOTS);
	localparam logic [PW-1:0] EMPTY = PW'(POOL_SLOTS);

	logic signed [VALUE_W-1:0] vals_mem [POOL_SLOTS];
	logic [PW-1:0]             links_mem [POOL_SLOTS];

	logic [PW-1:0]             head_q, tail_q, free_q;
	logic [IW-1:0]             init_idx_q;
	logic                      sorted_q;
	logic                      out_valid_q;
	pll_out_t                  out_q;

	logic signed [VALUE_W-1:0] key_q;
	logic                      mode_q;
	logic [IW-1:0]             p_q;
	logic [PW-1:0]             cur_q, prev_q, steps_q;
	logic signed [VALUE_W-1:0] rd_val_q;
	logic [PW-1:0]             rd_link_q;

	logic                      lk_we, lk_re;
	logic [IW-1:0]             lk_wa, lk_ra;
	logic [PW-1:0]             lk_wd;
	logic [PW-1:0]             p_ext;
	logic                      head_ok, prev_ok, next_ok, cur_ok;

	assign p_ext   = PW'(p_q);
	assign head_ok = head_q < EMPTY;
	assign prev_ok = prev_q < EMPTY;
	assign cur_ok  = cur_q < EMPTY;
	assign next_ok = rd_link_q < EMPTY;

	always_comb begin
		lk_we = 1'b0;
		lk_wa = cur_q[IW-1:0];
		lk_wd = free_q;
		if (cmd.init_wr) begin
			lk_we = 1'b1;
			lk_wa = init_idx_q;
			lk_wd = PW'(init_idx_q) + PW'(1);
		end else if (cmd.ins_link) begin
			lk_we = 1'b1;
			lk_wa = p_q;
			if (!head_ok) begin
				lk_wd = EMPTY;
			end else if (!prev_ok) begin
				lk_wd = head_q;
			end else begin
				lk_wd = cur_q;
			end
		end else if (cmd.ins_prev) begin
			lk_we = 1'b1;
			lk_wa = prev_q[IW-1:0];
			lk_wd = p_ext;
		end else if (cmd.rem_unlink) begin
			lk_we = prev_ok;
			lk_wa = prev_q[IW-1:0];
			lk_wd = rd_link_q;
		end else if (cmd.rem_push) begin
			lk_we = 1'b1;
			lk_wa = cur_q[IW-1:0];
			lk_wd = free_q;
		end
	end

	assign lk_re = cmd.free_rd | cmd.walk_rd;
	assign lk_ra = cmd.free_rd ? free_q[IW-1:0] : cur_q[IW-1:0];

	always_ff @(posedge clk) begin
		if (cmd.free_rd) vals_mem[free_q[IW-1:0]] <= key_q;
		if (cmd.walk_rd) rd_val_q <= vals_mem[cur_q[IW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (lk_we) links_mem[lk_wa] <= lk_wd;
		if (lk_re) rd_link_q <= links_mem[lk_ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q      <= EMPTY;
			tail_q      <= EMPTY;
			free_q      <= '0;
			init_idx_q  <= '0;
			sorted_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) sorted_q <= cfg_data;
			if (cmd.init_wr) init_idx_q <= init_idx_q + IW'(1);
			if (cmd.free_upd) free_q <= rd_link_q;
			if (cmd.rem_push) free_q <= cur_q;
			if (cmd.ins_link) begin
				if (!head_ok) begin
					head_q <= p_ext;
					tail_q <= p_ext;
				end else if (!prev_ok) begin
					head_q <= p_ext;
				end
			end
			if (cmd.ins_prev && prev_q == tail_q) tail_q <= p_ext;
			if (cmd.rem_unlink) begin
				if (!prev_ok && !next_ok) begin
					head_q <= EMPTY;
					tail_q <= EMPTY;
				end else begin
					if (!prev_ok) head_q <= rd_link_q;
					if (cur_q == tail_q) tail_q <= prev_q;
				end
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			key_q  <= in_data.value;
			mode_q <= in_data.mode;
		end
		if (cmd.free_rd) p_q <= free_q[IW-1:0];
		if (cmd.walk_init) begin
			prev_q  <= EMPTY;
			cur_q   <= head_q;
			steps_q <= '0;
		end
		if (cmd.prev_tail) begin
			prev_q <= tail_q;
			cur_q  <= EMPTY;
		end
		if (cmd.walk_adv) begin
			prev_q  <= cur_q;
			cur_q   <= rd_link_q;
			steps_q <= steps_q + PW'(1);
		end
		if (cmd.emit) begin
			out_q.status <= cmd.res;
			if (cmd.res == RES_DONE) begin
				out_q.slot <= (mode_q == MODE_REMOVE) ? SLOT_W'(cur_q[IW-1:0]) : SLOT_W'(p_q);
			end else begin
				out_q.slot <= '0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_comb begin
		sts.init_last = init_idx_q == IW'(POOL_SLOTS - 1);
		sts.mode      = mode_q;
		sts.sorted    = sorted_q;
		sts.pool_full = !(free_q < EMPTY);
		sts.walk_more = (steps_q < EMPTY) && cur_ok;
		sts.ge        = rd_val_q >= key_q;
		sts.eq        = rd_val_q == key_q;
		sts.gt        = rd_val_q > key_q;
		sts.link_prev = head_ok && prev_ok;
		sts.out_free  = !out_valid_q || out_ready;
	end

endmodule

// ===== rtl/core/pooled_linked_list_engine_unit.sv =====
// Top level of the pooled linked list engine: controller plus datapath.
//
//   channel  direction  handshake            payload
//   cfg      in         cfg_valid/cfg_ready  cfg_data (keep_sorted)
//   in       in         in_valid/in_ready    in_data  (mode, value)
//   out      out        out_valid/out_ready  out_data (status, slot)
//
// One item at a time. A full pool gives its result without touching the lists, an
// unsorted insert links the new node in at the tail, and a sorted insert or a
// remove walks the list node by node; each step reads value and link from the
// pools and compares. The next transfer can follow in the cycle after the result
// is written.
// After reset a sweep over all POOL_SLOTS slots builds the free list; in_ready is
// low meanwhile, configuration writes are taken. A result waiting on out_ready
// holds the controller in its final state; the next item is taken once the
// result register has accepted it.
module pooled_linked_list_engine_unit #(
	parameter int POOL_SLOTS = pll_pkg::POOL_SLOTS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic              cfg_data,
	input  logic              in_valid,
	output logic              in_ready,
	input  pll_pkg::pll_in_t  in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output pll_pkg::pll_out_t out_data
);
	import pll_pkg::*;

	pll_cmd_t cmd;
	pll_sts_t sts;

	assign cfg_ready = 1'b1;

	pll_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	pll_datapath #(
		.POOL_SLOTS (POOL_SLOTS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_data  (cfg_data),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cmd       (cmd),
		.sts       (sts)
	);

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input transfer taken while an item is in work");

	a_emit_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> sts.out_free)
		else $error("result written over a pending result");

	a_slot_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status != RES_DONE |-> out_data.slot == '0)
		else $error("nonzero slot on a failed operation");

endmodule
